/* hw/rtl/kpsd_pkg.sv */
// kpsd_pkg: shared constants for the keypad scanner and display mux
// holds key matrix geometry, register map and the seven-segment table
// no dependencies
package kpsd_pkg;

  localparam int unsigned KeyRows = 4;
  localparam int unsigned KeyCols = 3;
  localparam int unsigned KeyBits = 12;
  localparam int unsigned CodeW   = 4;
  localparam int unsigned SegW    = 8;
  localparam int unsigned DselW   = 2;
  localparam int unsigned PeriodW = 8;
  localparam int unsigned AddrW   = 3;

  localparam logic [AddrW-1:0]   AddrScanPeriod  = 3'd0;
  localparam logic [PeriodW-1:0] ScanPeriodReset = 8'd24;

  // active-low patterns indexed by key code, code 0 is blank
  localparam logic [SegW-1:0] SegTable [16] = '{
    8'hff, 8'hbb, 8'h62, 8'h2a, 8'h39, 8'h2c, 8'h24, 8'hba,
    8'h20, 8'h28, 8'h70, 8'ha0, 8'h64, 8'hb0, 8'hff, 8'hff
  };

  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 16;

endpackage

/* hw/rtl/keypad_scan_display_mux_top.sv */
// keypad_scan_display_mux_top: keypad scanner with multiplexed seven-segment display
// depends on kpsd_pkg
//
// One input word carries the sampled key matrix. Each accepted word yields exactly one
// output word in the next cycle. A new word can be taken every cycle while the output side
// keeps up. A result waiting in the output register holds the input off until it leaves,
// and the next word is taken in the same cycle that it leaves. Each word drives the next
// display digit (segments and digit index). Every scan_period words the matrix is compared
// with the stored key states. The last new press in scan order is reported as
// key_event/key_code and is shifted into the display store. A scan_period of zero scans
// every 256 words.
module keypad_scan_display_mux_top #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input word
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [kpsd_pkg::InTdataW-1:0]         s_axis_tdata,   // key_matrix[11:0]
  // output word
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [kpsd_pkg::OutTdataW-1:0]        m_axis_tdata,   // segments, digit_select, key_code
  output logic                                  m_axis_tuser,   // key_event
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [kpsd_pkg::AddrW-1:0]            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int unsigned IdxW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_DIGITS - 1);

  logic [kpsd_pkg::PeriodW-1:0] scan_period_q;
  logic [kpsd_pkg::KeyBits-1:0] key_state_q, key_state_d;
  logic [IdxW-1:0]              digit_idx_q, digit_idx_d;
  logic [kpsd_pkg::PeriodW-1:0] scan_cnt_q, scan_cnt_d, cnt_inc;
  logic [kpsd_pkg::CodeW-1:0]   disp_q [NUM_DIGITS];

  logic                         out_valid_q;
  logic [kpsd_pkg::SegW-1:0]    seg_q, seg_d;
  logic [kpsd_pkg::DselW-1:0]   dsel_q, dsel_d;
  logic                         event_q, event_d;
  logic [kpsd_pkg::CodeW-1:0]   code_q, code_d;

  logic                         accept;
  logic                         cfg_wr;
  logic                         scan_hit;
  logic [IdxW-1:0]              pos;
  logic [7:0]                   idx_ext;
  logic [kpsd_pkg::KeyBits-1:0] pressed, new_press;
  logic                         any_new;
  logic [kpsd_pkg::CodeW-1:0]   new_code;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr == kpsd_pkg::AddrScanPeriod);
  assign prdata = (paddr == kpsd_pkg::AddrScanPeriod) ? {24'd0, scan_period_q} : 32'd0;

  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;

  // display side
  assign pos     = LastIdx - digit_idx_q;
  assign seg_d   = kpsd_pkg::SegTable[disp_q[pos]];
  assign idx_ext = 8'(digit_idx_q);
  assign dsel_d  = idx_ext[1:0];
  assign digit_idx_d = (digit_idx_q == LastIdx) ? '0 : digit_idx_q + 1'b1;

  // scan timing
  assign cnt_inc    = scan_cnt_q + 8'd1;
  assign scan_hit   = (cnt_inc == scan_period_q);
  assign scan_cnt_d = scan_hit ? '0 : cnt_inc;

  // edge detect and priority pick, last new press in scan order wins
  assign pressed   = s_axis_tdata[kpsd_pkg::KeyBits-1:0];
  assign new_press = pressed & ~key_state_q;

  always_comb begin
    int bitn;
    any_new  = 1'b0;
    new_code = '0;
    for (int c = int'(kpsd_pkg::KeyCols) - 1; c >= 0; c--) begin
      for (int r = 0; r < int'(kpsd_pkg::KeyRows); r++) begin
        bitn = r * int'(kpsd_pkg::KeyCols) + c;
        if (new_press[bitn]) begin
          any_new  = 1'b1;
          new_code = kpsd_pkg::CodeW'(bitn + 1);
        end
      end
    end
  end

  assign key_state_d = scan_hit ? pressed : key_state_q;
  assign event_d     = scan_hit & any_new;
  assign code_d      = event_d ? new_code : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_period_q <= kpsd_pkg::ScanPeriodReset;
    end else if (cfg_wr) begin
      scan_period_q <= pwdata[kpsd_pkg::PeriodW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_state_q <= '0;
      digit_idx_q <= '0;
      scan_cnt_q  <= '0;
      for (int k = 0; k < int'(NUM_DIGITS); k++) begin
        disp_q[k] <= '0;
      end
    end else if (accept) begin
      key_state_q <= key_state_d;
      digit_idx_q <= digit_idx_d;
      scan_cnt_q  <= scan_cnt_d;
      if (event_d) begin
        for (int k = 0; k < int'(NUM_DIGITS) - 1; k++) begin
          disp_q[k] <= disp_q[k+1];
        end
        disp_q[NUM_DIGITS-1] <= new_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      seg_q   <= seg_d;
      dsel_q  <= dsel_d;
      event_q <= event_d;
      code_q  <= code_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, code_q, dsel_q, seg_q};
  assign m_axis_tuser  = event_q;

endmodule

/* hw/rtl/kpsd_checker.sv */
// kpsd_checker: port-level checks for keypad_scan_display_mux_top
// depends on kpsd_pkg, bound to the top level below
module kpsd_checker #(
  parameter int unsigned NUM_DIGITS = 4
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [kpsd_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);

  logic       out_acc;
  logic [2:0] dsel_next;

  assign out_acc   = m_axis_tvalid & m_axis_tready;
  assign dsel_next = (3'({1'b0, m_axis_tdata[9:8]}) + 3'd1 == 3'(NUM_DIGITS)) ?
                     3'd0 : 3'({1'b0, m_axis_tdata[9:8]}) + 3'd1;

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed under stall");

  // no code without an event
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[13:10] == 4'd0)
    else $error("key code set without key event");

  // event codes stay within the key range
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[13:10] != 4'd0
      && m_axis_tdata[13:10] <= 4'd12)
    else $error("key code out of range");

  // digit index advances by one, wrapping, between words accepted back to back
  a_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc ##1 out_acc |-> m_axis_tdata[9:8] == $past(dsel_next[1:0]))
    else $error("digit select did not advance");

endmodule

bind keypad_scan_display_mux_top kpsd_checker #(.NUM_DIGITS(NUM_DIGITS)) u_kpsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/keypad_scan_display_mux_top_tb.sv */
// keypad_scan_display_mux_top_tb: self-checking bench for the keypad scanner and display mux
// drives key matrix words and scan_period writes, predicts every output word and compares
// depends on kpsd_pkg and keypad_scan_display_mux_top
`timescale 1ns / 100ps

module keypad_scan_display_mux_top_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned IdlePct    = 26;
  localparam int unsigned MaxPrints  = 50;

  typedef struct packed {
    logic [kpsd_pkg::SegW-1:0]  seg;
    logic [kpsd_pkg::DselW-1:0] dsel;
    logic                       evt;
    logic [kpsd_pkg::CodeW-1:0] code;
  } tick_word_t;

  localparam logic [kpsd_pkg::SegW-1:0] SegPattern [16] = '{
    8'hff, 8'hbb, 8'h62, 8'h2a, 8'h39, 8'h2c, 8'h24, 8'hba,
    8'h20, 8'h28, 8'h70, 8'ha0, 8'h64, 8'hb0, 8'hff, 8'hff
  };

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [kpsd_pkg::InTdataW-1:0]  s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [kpsd_pkg::OutTdataW-1:0] m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [kpsd_pkg::AddrW-1:0]     paddr = '0;
  logic [31:0]                    pwdata = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  keypad_scan_display_mux_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // predicted block state
  logic [kpsd_pkg::PeriodW-1:0] period_cfg = kpsd_pkg::ScanPeriodReset;
  logic [kpsd_pkg::KeyBits-1:0] keys_down = '0;
  logic [kpsd_pkg::DselW-1:0]   shown_digit = '0;
  logic [kpsd_pkg::PeriodW-1:0] tick_cnt = '0;
  logic [kpsd_pkg::CodeW-1:0]   digit_store [4] = '{default: '0};

  tick_word_t  expected_words [$];
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  logic [kpsd_pkg::KeyBits-1:0] held_keys = '0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic tick_word_t predict_tick(input logic [kpsd_pkg::KeyBits-1:0] matrix);
    tick_word_t  w;
    int unsigned b;
    w.seg  = SegPattern[digit_store[3 - shown_digit]];
    w.dsel = shown_digit;
    w.evt  = 1'b0;
    w.code = '0;
    shown_digit = shown_digit + 1'b1;
    tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt == period_cfg) begin
      tick_cnt = '0;
      for (int col = kpsd_pkg::KeyCols - 1; col >= 0; col--) begin
        for (int row = 0; row < kpsd_pkg::KeyRows; row++) begin
          b = row * kpsd_pkg::KeyCols + col;
          if (matrix[b]) begin
            if (!keys_down[b]) begin
              keys_down[b] = 1'b1;
              w.evt  = 1'b1;
              w.code = kpsd_pkg::CodeW'(b + 1);
            end
          end else begin
            keys_down[b] = 1'b0;
          end
        end
      end
      if (w.evt) begin
        for (int k = 0; k < 3; k++) digit_store[k] = digit_store[k + 1];
        digit_store[3] = w.code;
      end
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_cnt < MaxPrints)
      $display("%0t mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // input prediction and output checking
  always @(posedge clk_i) begin
    tick_word_t w;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_words.push_back(predict_tick(s_axis_tdata[kpsd_pkg::KeyBits-1:0]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata, 0);
        end else begin
          w = expected_words.pop_front();
          if (m_axis_tdata[7:0] !== w.seg) report_mismatch("segments", m_axis_tdata[7:0], w.seg);
          if (m_axis_tdata[9:8] !== w.dsel)
            report_mismatch("digit_select", m_axis_tdata[9:8], w.dsel);
          if (m_axis_tdata[13:10] !== w.code)
            report_mismatch("key_code", m_axis_tdata[13:10], w.code);
          if (m_axis_tdata[15:14] !== 2'b00) report_mismatch("tdata pad", m_axis_tdata[15:14], 0);
          if (m_axis_tuser !== w.evt) report_mismatch("key_event", m_axis_tuser, w.evt);
        end
      end
    end
  end

  // receiver with random stalls and long hold-off
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !recv_idle || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_word(input logic [kpsd_pkg::KeyBits-1:0] matrix);
    while (send_idle && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(kpsd_pkg::InTdataW - kpsd_pkg::KeyBits){1'b0}}, matrix};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_scan_period(input logic [kpsd_pkg::PeriodW-1:0] val);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= kpsd_pkg::AddrScanPeriod;
    pwdata  <= {{(32 - kpsd_pkg::PeriodW){1'b0}}, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    period_cfg = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[kpsd_pkg::PeriodW-1:0] !== val)
      report_mismatch("scan_period readback", prdata, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // held keys change now and then, with some noisy samples in between
  function automatic logic [kpsd_pkg::KeyBits-1:0] next_keys(input int unsigned change_pct);
    if ($urandom_range(99) < change_pct) begin
      case ($urandom_range(2))
        0:       held_keys = '0;
        1:       held_keys = kpsd_pkg::KeyBits'(1) << $urandom_range(kpsd_pkg::KeyBits - 1);
        default: held_keys = kpsd_pkg::KeyBits'($urandom());
      endcase
    end
    if ($urandom_range(99) < 5) return kpsd_pkg::KeyBits'($urandom());
    return held_keys;
  endfunction

  task automatic run_keys(input int unsigned n, input int unsigned change_pct);
    repeat (n) send_word(next_keys(change_pct));
  endtask

  task automatic test_reset_period();
    run_keys(60, 5);
  endtask

  task automatic test_directed_keys();
    set_scan_period(8'd1);
    send_word('0);
    for (int b = 0; b < kpsd_pkg::KeyBits; b++) begin
      send_word(kpsd_pkg::KeyBits'(1) << b);
      send_word('0);
    end
    send_word('1);
    send_word('0);
  endtask

  task automatic test_full_rate_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    set_scan_period(8'd1);
    hold_req = 150;
    run_keys(350, 20);
    wait_drained();
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  task automatic test_short_periods();
    logic [kpsd_pkg::PeriodW-1:0] periods [5] = '{8'd2, 8'd3, 8'd5, 8'd7, 8'd13};
    foreach (periods[i]) begin
      set_scan_period(periods[i]);
      run_keys(60, 10);
    end
  endtask

  task automatic test_long_periods();
    set_scan_period(8'd255);
    run_keys(260, 1);
    set_scan_period(8'd0);
    run_keys(260, 1);
  endtask

  task automatic test_period_below_count();
    set_scan_period(8'd200);
    run_keys(100, 5);
    set_scan_period(8'd10);
    run_keys(250, 5);
  endtask

  task automatic test_random_periods();
    repeat (5) begin
      set_scan_period(kpsd_pkg::PeriodW'($urandom_range(1, 40)));
      run_keys(60, 15);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_period();
    test_directed_keys();
    test_full_rate_backpressure();
    test_short_periods();
    test_long_periods();
    test_period_below_count();
    test_random_periods();
    wait_drained();
    if (expected_words.size() != 0) report_mismatch("words left over", expected_words.size(), 0);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/kpsd_pkg.sv
hw/rtl/keypad_scan_display_mux_top.sv
hw/rtl/kpsd_checker.sv
tb/keypad_scan_display_mux_top_tb.sv
